FILE: design/tclru_pkg.sv
// Shared types and constants for the tile cache LRU lookup directory.
package tclru_pkg;

  localparam int SLOT_BITS = 6;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } tclru_state_t;

  // search state travelling along the cell chain
  typedef struct packed {
    logic valid;
    logic hit;
    logic have_empty;
    logic have_victim;
  } tclru_flags_t;

  // write-back control broadcast to every cell
  typedef struct packed {
    logic en;
    logic tag_en;
  } tclru_wr_t;

endpackage

FILE: design/tclru_cell.sv
// One directory slot: holds tag and last-use time, and advances the search one stage.
module tclru_cell #(
  parameter int TAG_BITS  = 32,
  parameter int TIME_BITS = 32,
  parameter int IW        = 6,
  parameter int INDEX     = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  flush,
  input  tclru_pkg::tclru_wr_t  wr,
  input  logic [IW-1:0]         wr_idx,
  input  logic [TAG_BITS-1:0]   wr_tag,
  input  logic [TIME_BITS-1:0]  wr_time,
  input  logic [TAG_BITS-1:0]   qtag,
  input  tclru_pkg::tclru_flags_t flags_in,
  input  logic [IW-1:0]         hit_idx_in,
  input  logic [IW-1:0]         empty_idx_in,
  input  logic [IW-1:0]         victim_idx_in,
  input  logic [TIME_BITS-1:0]  victim_time_in,
  output tclru_pkg::tclru_flags_t flags_out,
  output logic [IW-1:0]         hit_idx_out,
  output logic [IW-1:0]         empty_idx_out,
  output logic [IW-1:0]         victim_idx_out,
  output logic [TIME_BITS-1:0]  victim_time_out
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [TAG_BITS-1:0]     tag;
  logic [TIME_BITS-1:0]    tstamp;
  logic                    is_empty;
  logic                    is_match;
  tclru_pkg::tclru_flags_t flags_next;
  logic [IW-1:0]           hit_idx_next;
  logic [IW-1:0]           empty_idx_next;
  logic [IW-1:0]           victim_idx_next;
  logic [TIME_BITS-1:0]    victim_time_next;

  assign is_empty = (tag == {TAG_BITS{1'b1}});
  assign is_match = !is_empty && (tag == qtag);

  always_comb begin
    flags_next       = flags_in;
    hit_idx_next     = hit_idx_in;
    empty_idx_next   = empty_idx_in;
    victim_idx_next  = victim_idx_in;
    victim_time_next = victim_time_in;
    if (flags_in.valid && !flags_in.hit) begin
      if (is_empty) begin
        flags_next.have_empty = 1'b1;
        empty_idx_next        = MY_IDX;
      end else if (is_match) begin
        flags_next.hit = 1'b1;
        hit_idx_next   = MY_IDX;
      end else if (!flags_in.have_victim || (tstamp < victim_time_in)) begin
        flags_next.have_victim = 1'b1;
        victim_idx_next        = MY_IDX;
        victim_time_next       = tstamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out <= '0;
    end else begin
      flags_out <= flags_next;
    end
    hit_idx_out     <= hit_idx_next;
    empty_idx_out   <= empty_idx_next;
    victim_idx_out  <= victim_idx_next;
    victim_time_out <= victim_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      tag <= {TAG_BITS{1'b1}};
    end else if (wr.en && wr.tag_en && (wr_idx == MY_IDX)) begin
      tag <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr_idx == MY_IDX)) begin
      tstamp <= wr_time;
    end
  end

endmodule

FILE: design/tile_cache_lru_lookup_top.sv
// Top level of the tile cache LRU lookup directory: control, cell chain and result register.
//
//  transaction | ports                          | handshake
//  ------------+--------------------------------+------------------------------
//  request     | operation, tag, now            | taken when start && !busy
//  result      | hit, slot, fill, evicted       | one-cycle done strobe, no stall
//
//  A lookup walks the chain one cell per cycle: done rises once the request has passed the
//  launch register, every cell of the chain and the result register, and the next transaction
//  can be taken in the cycle that done rises. A flush never raises busy and can be followed at once.
//  Synchronous reset empties every slot at once; slot times are left as they are.
//  The receiver cannot hold off results; busy is high while a lookup is in the chain.
module tile_cache_lru_lookup_top #(
  parameter int ENTRIES   = 64,
  parameter int TAG_BITS  = 32,
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation,
  input  logic [TAG_BITS-1:0]            tag,
  input  logic [TIME_BITS-1:0]           now,
  output logic                           done,
  output logic                           hit,
  output logic [tclru_pkg::SLOT_BITS-1:0] slot,
  output logic                           fill,
  output logic                           evicted
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SB = tclru_pkg::SLOT_BITS;

  tclru_pkg::tclru_state_t state, state_next;

  logic                   accept;
  logic                   flush_acc;
  logic                   launch;
  logic [TAG_BITS-1:0]    qtag;
  logic [TIME_BITS-1:0]   qtime;

  tclru_pkg::tclru_flags_t chain_flags [ENTRIES+1];
  logic [IW-1:0]           chain_hit_idx [ENTRIES+1];
  logic [IW-1:0]           chain_empty_idx [ENTRIES+1];
  logic [IW-1:0]           chain_victim_idx [ENTRIES+1];
  logic [TIME_BITS-1:0]    chain_victim_time [ENTRIES+1];

  tclru_pkg::tclru_flags_t fin;
  tclru_pkg::tclru_wr_t    wr;
  logic [IW-1:0]           chosen;
  logic [IW+SB-1:0]        chosen_ext;

  assign accept    = start && !busy;
  assign flush_acc = accept && (operation == tclru_pkg::OP_FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tclru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    case (state)
      tclru_pkg::ST_IDLE: begin
        if (start && (operation == tclru_pkg::OP_LOOKUP)) begin
          state_next = tclru_pkg::ST_SCAN;
        end
      end
      tclru_pkg::ST_SCAN: begin
        busy = 1'b1;
        if (fin.valid) begin
          state_next = tclru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tclru_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= accept && (operation == tclru_pkg::OP_LOOKUP);
    end
    if (accept) begin
      qtag  <= tag;
      qtime <= now;
    end
  end

  always_comb begin
    chain_flags[0]             = '0;
    chain_flags[0].valid       = launch;
    chain_hit_idx[0]           = '0;
    chain_empty_idx[0]         = '0;
    chain_victim_idx[0]        = '0;
    chain_victim_time[0]       = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tclru_cell #(
      .TAG_BITS  (TAG_BITS),
      .TIME_BITS (TIME_BITS),
      .IW        (IW),
      .INDEX     (i)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .flush           (flush_acc),
      .wr              (wr),
      .wr_idx          (chosen),
      .wr_tag          (qtag),
      .wr_time         (qtime),
      .qtag            (qtag),
      .flags_in        (chain_flags[i]),
      .hit_idx_in      (chain_hit_idx[i]),
      .empty_idx_in    (chain_empty_idx[i]),
      .victim_idx_in   (chain_victim_idx[i]),
      .victim_time_in  (chain_victim_time[i]),
      .flags_out       (chain_flags[i+1]),
      .hit_idx_out     (chain_hit_idx[i+1]),
      .empty_idx_out   (chain_empty_idx[i+1]),
      .victim_idx_out  (chain_victim_idx[i+1]),
      .victim_time_out (chain_victim_time[i+1])
    );
  end

  // end of chain: pick the slot and write it back
  assign fin = chain_flags[ENTRIES];

  always_comb begin
    if (fin.hit) begin
      chosen = chain_hit_idx[ENTRIES];
    end else if (fin.have_empty) begin
      chosen = chain_empty_idx[ENTRIES];
    end else begin
      chosen = chain_victim_idx[ENTRIES];
    end
    wr.en      = fin.valid;
    wr.tag_en  = fin.valid && !fin.hit;
    chosen_ext = {{SB{1'b0}}, chosen};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= flush_acc || fin.valid;
    end
    if (flush_acc) begin
      hit     <= 1'b0;
      slot    <= '0;
      fill    <= 1'b0;
      evicted <= 1'b0;
    end else if (fin.valid) begin
      hit     <= fin.hit;
      slot    <= chosen_ext[SB-1:0];
      fill    <= !fin.hit;
      evicted <= !fin.hit && !fin.have_empty;
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done && !$past(rst) |-> $past(flush_acc) || $past(fin.valid))
    else $error("done without a finished transaction");

  a_fin_in_scan: assert property (@(posedge clk) disable iff (rst)
    fin.valid |-> state == tclru_pkg::ST_SCAN)
    else $error("chain result outside a lookup");

  a_hit_no_fill: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && fill))
    else $error("hit and fill together");

  a_evict_fill: assert property (@(posedge clk) disable iff (rst)
    done && evicted |-> fill)
    else $error("eviction without fill");

  a_launch_idle: assert property (@(posedge clk) disable iff (rst)
    launch |-> $past(state) == tclru_pkg::ST_IDLE)
    else $error("lookup launched while busy");

endmodule
